// ===== design/a32dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM32 decoder package
// Group codes, flag bit positions, match patterns and the decoded result type
// shared by the ARM-state instruction decoder.
// ----------------------------------------------------------------------------
package a32dec_pkg;

    // Instruction groups, as presented on the group port.
    typedef enum logic [3:0] {
        GRP_INVALID  = 4'd0,
        GRP_DATAPROC = 4'd1,
        GRP_MUL      = 4'd2,
        GRP_MULL     = 4'd3,
        GRP_SWAP     = 4'd4,
        GRP_BX       = 4'd5,
        GRP_XFER     = 4'd6,
        GRP_HALF     = 4'd7,
        GRP_BLOCK    = 4'd8,
        GRP_BRANCH   = 4'd9,
        GRP_SWI      = 4'd10
    } grp_t;

    // Bit positions inside the flags field.
    localparam int unsigned FLAG_W    = 9;
    localparam int unsigned FB_SETC   = 0;
    localparam int unsigned FB_IMM    = 1;
    localparam int unsigned FB_PRE    = 2;
    localparam int unsigned FB_UP     = 3;
    localparam int unsigned FB_BYTE   = 4;
    localparam int unsigned FB_WB     = 5;
    localparam int unsigned FB_LOAD   = 6;
    localparam int unsigned FB_LINK   = 7;
    localparam int unsigned FB_SIGN   = 8;

    // Encoding patterns.
    localparam logic [21:0] BX_PATTERN   = 22'b0100101111111111110001;
    localparam logic [4:0]  OP_MULL      = 5'b00001;
    localparam logic [4:0]  OP_SWAP      = 5'b00010;
    localparam logic [4:0]  OP_MUL       = 5'b00000;
    localparam logic [3:0]  MUL_NIBBLE   = 4'b1001;
    localparam logic [1:0]  SWI_TOP      = 2'b11;

    // Major class, bits 27..26.
    localparam logic [1:0]  CLS_DP       = 2'b00;
    localparam logic [1:0]  CLS_XFER     = 2'b01;
    localparam logic [1:0]  CLS_BRANCH   = 2'b10;

    typedef struct packed {
        grp_t              group;
        logic [3:0]        condition;
        logic [3:0]        alu_opcode;
        logic [FLAG_W-1:0] flags;
        logic [3:0]        reg_d;
        logic [3:0]        reg_n;
        logic [3:0]        reg_m;
        logic [3:0]        reg_s;
        logic [1:0]        shift_kind;
        logic              shift_by_register;
        logic [4:0]        shift_amount;
        logic [31:0]       immediate;
    } decode_t;

endpackage

// ===== design/arm32_instruction_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM32 instruction decoder unit
// Classifies one ARM-state word per cycle unless stalled and extracts its fields.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel (in_valid, in_stall, instruction) carries
//   one 32-bit instruction word. It is captured in an input register, decoded
//   by shallow field-extraction logic and stored in a result register that
//   drives the output channel (out_valid, out_stall and the decoded fields).
//   out_valid rises once an accepted request moves from the input register
//   into the result register, which a stalled output delays. Throughput is one
//   request per cycle for as long as the receiver does not stall; the only
//   logic of note between the registers is the 32-bit rotator of the
//   data-processing immediate.
//   When out_stall is high the result register holds its request; the input
//   register still takes one more request, and only then is in_stall raised.
//   in_stall depends on out_stall and on the two valid flags only.
//   Reset clears both valid flags, so the block comes up empty and ready.
//   Fields that a group does not use read as zero; an invalid word shows only
//   its condition.
// ----------------------------------------------------------------------------
module arm32_instruction_decoder_unit
    import a32dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  group,
    output logic [3:0]  condition,
    output logic [3:0]  alu_opcode,
    output logic [8:0]  flags,
    output logic [3:0]  reg_d,
    output logic [3:0]  reg_n,
    output logic [3:0]  reg_m,
    output logic [3:0]  reg_s,
    output logic [1:0]  shift_kind,
    output logic        shift_by_register,
    output logic [4:0]  shift_amount,
    output logic [31:0] immediate
);

    // Pipeline control.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    decode_t     res_reg;
    logic        s2_ready;
    logic        s1_ready;
    logic        s1_load;
    logic        s2_load;

    // Decode signals.
    decode_t     dec;
    logic [31:0] w;
    logic        mul_pat;
    logic [4:0]  op_top;
    logic [31:0] rot_val;
    logic [4:0]  rot_amt;
    logic [63:0] rot_wide;

    // The result register can take a new request when it is empty or drains.
    assign s2_ready = !out_valid_reg || !out_stall;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_valid && s1_ready;
    assign in_stall = !s1_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (s2_ready)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg <= instruction;
        end
        if (s2_load)
        begin
            res_reg <= dec;
        end
    end

    // Decode of the word held in the input register.
    assign w        = s1_word_reg;
    assign mul_pat  = (w[7:4] == MUL_NIBBLE);
    assign op_top   = w[27:23];
    // A rotate right by an even amount; a rotate of zero leaves the byte as is.
    assign rot_amt  = {w[11:8], 1'b0};
    assign rot_wide = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot_amt;
    assign rot_val  = rot_wide[31:0];

    always_comb
    begin
        dec           = '0;
        dec.group     = GRP_INVALID;
        dec.condition = w[31:28];
        case (w[27:26])
            CLS_DP:
            begin
                if (mul_pat && (op_top == OP_MUL || op_top == OP_MULL))
                begin
                    dec.group          = (op_top == OP_MUL) ? GRP_MUL : GRP_MULL;
                    dec.flags[FB_LINK] = w[21];
                    dec.flags[FB_SETC] = w[20];
                    dec.flags[FB_SIGN] = (op_top == OP_MULL) && w[22];
                    dec.reg_d          = w[19:16];
                    dec.reg_n          = w[15:12];
                    dec.reg_s          = w[11:8];
                    dec.reg_m          = w[3:0];
                end
                else if (mul_pat && op_top == OP_SWAP && w[11:8] == 4'd0)
                begin
                    dec.group          = GRP_SWAP;
                    dec.flags[FB_BYTE] = w[22];
                    dec.reg_n          = w[19:16];
                    dec.reg_d          = w[15:12];
                    dec.reg_m          = w[3:0];
                end
                else if (!mul_pat && w[25:4] == BX_PATTERN)
                begin
                    dec.group = GRP_BX;
                    dec.reg_m = w[3:0];
                end
                else if (!w[25] && w[7] && w[4] && (w[22] || w[11:8] == 4'd0))
                begin
                    // Halfword and signed transfer; bit 22 picks the split
                    // immediate offset over the register offset.
                    dec.group          = GRP_HALF;
                    dec.flags[FB_PRE]  = w[24];
                    dec.flags[FB_UP]   = w[23];
                    dec.flags[FB_WB]   = w[21];
                    dec.flags[FB_LOAD] = w[20];
                    dec.flags[FB_IMM]  = w[22];
                    dec.reg_n          = w[19:16];
                    dec.reg_d          = w[15:12];
                    dec.shift_kind     = w[6:5];
                    if (w[22])
                    begin
                        dec.immediate = {24'd0, w[11:8], w[3:0]};
                    end
                    else
                    begin
                        dec.reg_m = w[3:0];
                    end
                end
                else
                begin
                    dec.group          = GRP_DATAPROC;
                    dec.alu_opcode     = w[24:21];
                    dec.flags[FB_SETC] = w[20];
                    dec.flags[FB_IMM]  = w[25];
                    dec.reg_n          = w[19:16];
                    dec.reg_d          = w[15:12];
                    if (w[25])
                    begin
                        dec.immediate = rot_val;
                    end
                    else
                    begin
                        dec.shift_kind        = w[6:5];
                        dec.shift_by_register = w[4];
                        dec.shift_amount      = w[4] ? {1'b0, w[11:8]} : w[11:7];
                        dec.reg_m             = w[3:0];
                    end
                end
            end
            CLS_XFER:
            begin
                dec.group          = GRP_XFER;
                dec.flags[FB_IMM]  = !w[25];
                dec.flags[FB_PRE]  = w[24];
                dec.flags[FB_UP]   = w[23];
                dec.flags[FB_BYTE] = w[22];
                dec.flags[FB_WB]   = w[21];
                dec.flags[FB_LOAD] = w[20];
                dec.reg_n          = w[19:16];
                dec.reg_d          = w[15:12];
                if (w[25])
                begin
                    dec.shift_kind        = w[6:5];
                    dec.shift_by_register = w[4];
                    dec.shift_amount      = w[4] ? {1'b0, w[11:8]} : w[11:7];
                    dec.reg_m             = w[3:0];
                end
                else
                begin
                    dec.immediate = {20'd0, w[11:0]};
                end
            end
            CLS_BRANCH:
            begin
                if (w[25])
                begin
                    // Word offset, sign-extended from bit 25 after the shift.
                    dec.group          = GRP_BRANCH;
                    dec.flags[FB_LINK] = w[24];
                    dec.immediate      = {{6{w[23]}}, w[23:0], 2'b00};
                end
                else
                begin
                    dec.group          = GRP_BLOCK;
                    dec.flags[FB_PRE]  = w[24];
                    dec.flags[FB_UP]   = w[23];
                    dec.flags[FB_BYTE] = w[22];
                    dec.flags[FB_WB]   = w[21];
                    dec.flags[FB_LOAD] = w[20];
                    dec.reg_n          = w[19:16];
                    dec.immediate      = {16'd0, w[15:0]};
                end
            end
            default:
            begin
                // Coprocessor space is invalid; only the software interrupt
                // is recognised here.
                if (w[25:24] == SWI_TOP)
                begin
                    dec.group = GRP_SWI;
                end
            end
        endcase
    end

    // Outputs.
    assign out_valid         = out_valid_reg;
    assign group             = res_reg.group;
    assign condition         = res_reg.condition;
    assign alu_opcode        = res_reg.alu_opcode;
    assign flags             = res_reg.flags;
    assign reg_d             = res_reg.reg_d;
    assign reg_n             = res_reg.reg_n;
    assign reg_m             = res_reg.reg_m;
    assign reg_s             = res_reg.reg_s;
    assign shift_kind        = res_reg.shift_kind;
    assign shift_by_register = res_reg.shift_by_register;
    assign shift_amount      = res_reg.shift_amount;
    assign immediate         = res_reg.immediate;

    // The input side only stalls while the input register holds a request.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // A request leaving the input register shows up on the output next cycle.
    a_advance_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> out_valid)
        else $error("request lost between input and result register");

    // Only data processing carries an ALU opcode.
    a_alu_only_dataproc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && group != GRP_DATAPROC) |-> (alu_opcode == 4'd0))
        else $error("ALU opcode set outside data processing");

    // Invalid words and software interrupts carry nothing but the condition.
    a_bare_groups: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (group == GRP_INVALID || group == GRP_SWI))
        |-> (flags == 9'd0 && immediate == 32'd0 && reg_d == 4'd0 && reg_n == 4'd0))
        else $error("fields set for an invalid or software interrupt word");

endmodule
